// ----- rtl/hclit_pkg.sv -----
// hclit_pkg: shared widths, character codes, scanner types and result struct
// for the hex color literal scanner; no dependencies
package hclit_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_BQUOTE = 8'h60;

    localparam logic [3:0] DIGITS_NONE  = 4'd15;
    localparam logic [3:0] DIGITS_SHORT = 4'd6;
    localparam logic [3:0] DIGITS_LONG  = 4'd8;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // scanning mode, one-hot
    typedef enum logic [2:0] {
        MODE_CODE  = 3'b001,
        MODE_LINE  = 3'b010,
        MODE_BLOCK = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_DOUBLE = 2'd1,
        QUOTE_SINGLE = 2'd2,
        QUOTE_BACK   = 2'd3
    } quote_t;

    typedef struct packed {
        mode_t                  mode;
        quote_t                 quote;
        logic                   esc;
        logic [7:0]             held_byte;
        logic                   held_valid;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [3:0]             digits;
        logic [COLUMN_BITS-1:0] start;
        logic [31:0]            value;
    } scan_state_t;

    typedef struct packed {
        logic [LINE_BITS-1:0]   found_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [COLUMN_BITS-1:0] end_column;
        logic [7:0]             red_byte;
        logic [7:0]             green_byte;
        logic [7:0]             blue_byte;
        logic [7:0]             alpha_byte;
        logic                   has_alpha;
    } color_result_t;

endpackage

// ----- rtl/hclit_text_if.sv -----
// hclit_text_if: valid/ready channel carrying one text byte and its last flag
// depends on hclit_pkg only by convention (no types needed)
interface hclit_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- rtl/hclit_color_if.sv -----
// hclit_color_if: valid/ready channel carrying one found color literal
// depends on hclit_pkg for the line and column widths
interface hclit_color_if;
    import hclit_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LINE_BITS-1:0]   found_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [COLUMN_BITS-1:0] end_column;
    logic [7:0]             red_byte;
    logic [7:0]             green_byte;
    logic [7:0]             blue_byte;
    logic [7:0]             alpha_byte;
    logic                   has_alpha;

    modport source (
        output valid, output found_line, output start_column, output end_column,
        output red_byte, output green_byte, output blue_byte, output alpha_byte,
        output has_alpha, input ready
    );
    modport sink (
        input valid, input found_line, input start_column, input end_column,
        input red_byte, input green_byte, input blue_byte, input alpha_byte,
        input has_alpha, output ready
    );
endinterface

// ----- rtl/hclit_in_stage.sv -----
// hclit_in_stage: input register for the text channel
// depends on hclit_text_if
module hclit_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    hclit_text_if.sink   text,
    input  logic         take,
    output logic         item_valid,
    output logic [7:0]   item_byte,
    output logic         item_last
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       accept;

    assign text.ready = !valid_reg || take;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text.text_byte;
            last_reg <= text.end_of_text;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_last  = last_reg;
endmodule

// ----- rtl/hclit_core.sv -----
// hclit_core: scanner state registers and the per-byte update logic
// depends on hclit_pkg
module hclit_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              item_byte,
    input  logic                    item_last,
    output logic                    hit,
    output hclit_pkg::color_result_t result
);
    import hclit_pkg::*;

    localparam scan_state_t STATE_RESET = '{
        mode:       MODE_CODE,
        quote:      QUOTE_NONE,
        esc:        1'b0,
        held_byte:  8'h00,
        held_valid: 1'b0,
        line:       '0,
        col:        '0,
        digits:     DIGITS_NONE,
        start:      '0,
        value:      32'h0
    };

    // {is hex, digit value}
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            r = {1'b1, ch[3:0]};
        end
        else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
        begin
            r = {1'b1, 4'(ch[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic color_result_t make_result(
        input logic [LINE_BITS-1:0]   line,
        input logic [COLUMN_BITS-1:0] start,
        input logic [3:0]             digits,
        input logic [31:0]            value
    );
        color_result_t        r;
        logic [COLUMN_BITS:0] end_sum;
        end_sum = {1'b0, start} + (COLUMN_BITS + 1)'(digits) + (COLUMN_BITS + 1)'(1);
        r.found_line   = line;
        r.start_column = start;
        r.end_column   = end_sum[COLUMN_BITS] ? '1 : end_sum[COLUMN_BITS-1:0];
        if (digits == DIGITS_LONG)
        begin
            r.red_byte   = value[31:24];
            r.green_byte = value[23:16];
            r.blue_byte  = value[15:8];
            r.alpha_byte = value[7:0];
            r.has_alpha  = 1'b1;
        end
        else
        begin
            r.red_byte   = value[23:16];
            r.green_byte = value[15:8];
            r.blue_byte  = value[7:0];
            r.alpha_byte = ALPHA_OPAQUE;
            r.has_alpha  = 1'b0;
        end
        return r;
    endfunction

    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t s;
    logic [4:0]  hex;
    logic        done;
    logic [7:0]  close_char;

    always_comb
    begin
        s          = state_reg;
        hex        = hex_value(item_byte);
        done       = 1'b0;
        hit        = 1'b0;
        result     = make_result(state_reg.line, state_reg.start, state_reg.digits,
                                 state_reg.value);
        unique case (state_reg.quote)
            QUOTE_DOUBLE: close_char = CHAR_DQUOTE;
            QUOTE_SINGLE: close_char = CHAR_SQUOTE;
            QUOTE_BACK:   close_char = CHAR_BQUOTE;
            default:      close_char = CHAR_BQUOTE;
        endcase

        unique case (state_reg.mode)
            MODE_LINE:
            begin
                s.held_valid = 1'b0;
                if (item_byte == CHAR_LF)
                begin
                    s.mode = MODE_CODE;
                end
            end
            MODE_BLOCK:
            begin
                if (state_reg.held_valid && state_reg.held_byte == CHAR_STAR
                    && item_byte == CHAR_SLASH)
                begin
                    s.mode       = MODE_CODE;
                    s.held_valid = 1'b0;
                end
                else
                begin
                    s.held_valid = (item_byte == CHAR_STAR);
                end
            end
            default:
            begin
                // comment openers
                if (state_reg.held_valid && state_reg.held_byte == CHAR_SLASH)
                begin
                    s.held_valid = 1'b0;
                    if (item_byte == CHAR_SLASH)
                    begin
                        s.mode = MODE_LINE;
                        done   = 1'b1;
                    end
                    else if (item_byte == CHAR_STAR)
                    begin
                        s.mode       = MODE_BLOCK;
                        s.held_valid = 1'b1;
                        done         = 1'b1;
                    end
                end
                // pending candidate: extend, report or drop
                if (!done && state_reg.digits != DIGITS_NONE)
                begin
                    if (hex[4] && state_reg.digits < DIGITS_LONG)
                    begin
                        s.digits     = state_reg.digits + 4'd1;
                        s.value      = {state_reg.value[27:0], hex[3:0]};
                        s.held_valid = 1'b0;
                        done         = 1'b1;
                    end
                    else
                    begin
                        if (!hex[4] && (state_reg.digits == DIGITS_SHORT
                                        || state_reg.digits == DIGITS_LONG))
                        begin
                            hit = 1'b1;
                        end
                        else
                        begin
                            s.esc = 1'b0;
                        end
                        s.digits = DIGITS_NONE;
                    end
                end
                // ordinary byte
                if (!done)
                begin
                    s.held_valid = 1'b0;
                    if (item_byte == CHAR_HASH)
                    begin
                        s.digits = 4'd0;
                        s.value  = 32'h0;
                        s.start  = state_reg.col;
                    end
                    else if (state_reg.quote != QUOTE_NONE)
                    begin
                        if (s.esc)
                        begin
                            s.esc = 1'b0;
                        end
                        else if (item_byte == CHAR_BSLASH)
                        begin
                            s.esc = 1'b1;
                        end
                        else if (item_byte == close_char)
                        begin
                            s.quote = QUOTE_NONE;
                        end
                    end
                    else if (item_byte == CHAR_SLASH)
                    begin
                        s.held_valid = 1'b1;
                    end
                    else if (item_byte == CHAR_DQUOTE)
                    begin
                        s.quote = QUOTE_DOUBLE;
                    end
                    else if (item_byte == CHAR_SQUOTE)
                    begin
                        s.quote = QUOTE_SINGLE;
                    end
                    else if (item_byte == CHAR_BQUOTE)
                    begin
                        s.quote = QUOTE_BACK;
                    end
                end
            end
        endcase

        // every byte moves the position, saturating
        if (item_byte == CHAR_LF)
        begin
            if (state_reg.line != '1)
            begin
                s.line = state_reg.line + LINE_BITS'(1);
            end
            s.col = '0;
        end
        else if (state_reg.col != '1)
        begin
            s.col = state_reg.col + COLUMN_BITS'(1);
        end
        s.held_byte = item_byte;

        // end of document: flush a complete candidate, then start over
        state_next = s;
        if (item_last)
        begin
            if (!hit && s.mode == MODE_CODE
                && (s.digits == DIGITS_SHORT || s.digits == DIGITS_LONG))
            begin
                hit    = 1'b1;
                result = make_result(s.line, s.start, s.digits, s.value);
            end
            state_next = STATE_RESET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- rtl/hclit_out_stage.sv -----
// hclit_out_stage: result register driving the color channel
// depends on hclit_pkg and hclit_color_if
module hclit_out_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic                     hit,
    input  hclit_pkg::color_result_t result,
    output logic                     free,
    hclit_color_if.source            color
);
    import hclit_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    color_result_t result_reg;

    assign free = !valid_reg || color.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = hit;
        end
        else if (color.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && hit)
        begin
            result_reg <= result;
        end
    end

    assign color.valid        = valid_reg;
    assign color.found_line   = result_reg.found_line;
    assign color.start_column = result_reg.start_column;
    assign color.end_column   = result_reg.end_column;
    assign color.red_byte     = result_reg.red_byte;
    assign color.green_byte   = result_reg.green_byte;
    assign color.blue_byte    = result_reg.blue_byte;
    assign color.alpha_byte   = result_reg.alpha_byte;
    assign color.has_alpha    = result_reg.has_alpha;
endmodule

// ----- rtl/hex_color_literal_scanner.sv -----
// hex_color_literal_scanner: top level of the hex color literal scanner
// depends on hclit_pkg, hclit_text_if, hclit_color_if, hclit_in_stage,
// hclit_core and hclit_out_stage
//
// usage
//   text  : sink channel, one document byte per transfer plus end_of_text,
//           which marks the final byte of a document
//   color : source channel, one transfer per '#' literal with exactly six
//           or eight hex digits found in code or inside a string (never in
//           a comment): line, start/end column and the four color bytes
//   a literal is reported on the byte right after its last digit, or on
//   the final byte of the document; after the final byte all scanner state
//   returns to reset, so the next byte begins a new document
//   path: the byte that completes a result passes the input register, then
//   the result register, which holds the result while it is valid on color
//   throughput: one byte per cycle while color is not held off; the
//   per-byte state update is a single pass of logic between the input
//   register and the result register
//   stall: while color is held off, one finished result waits in the result
//   register and one byte waits in the input register; text.ready drops
//   only when both are occupied
//   reset: rst_n is asynchronous, active low; it empties both registers
//   and puts the scanner in code mode at line 0, column 0
module hex_color_literal_scanner (
    input  logic          clk,
    input  logic          rst_n,
    hclit_text_if.sink    text,
    hclit_color_if.source color
);
    import hclit_pkg::*;

    logic          item_valid;
    logic [7:0]    item_byte;
    logic          item_last;
    logic          free;
    logic          step;
    logic          hit;
    color_result_t result;

    // a byte is processed when the result register can take its outcome
    assign step = item_valid && free;

    hclit_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .take       (step),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_last  (item_last)
    );

    hclit_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item_byte (item_byte),
        .item_last (item_last),
        .hit       (hit),
        .result    (result)
    );

    hclit_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (step),
        .hit    (hit),
        .result (result),
        .free   (free),
        .color  (color)
    );
endmodule
